// ===== sv/mdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// mdsc_pkg: shared types and constants of the method descriptor slot counter
// Character codes, parser phases, error and return-kind codes, and the
// item and result records passed between the stages.
// ----------------------------------------------------------------------------
`default_nettype none

package mdsc_pkg;

    // Descriptor characters
    localparam logic [7:0] CH_OPEN   = 8'h28; // '('
    localparam logic [7:0] CH_CLOSE  = 8'h29; // ')'
    localparam logic [7:0] CH_SEMI   = 8'h3B; // ';'
    localparam logic [7:0] CH_BYTE   = 8'h42; // 'B'
    localparam logic [7:0] CH_CHAR   = 8'h43; // 'C'
    localparam logic [7:0] CH_DOUBLE = 8'h44; // 'D'
    localparam logic [7:0] CH_FLOAT  = 8'h46; // 'F'
    localparam logic [7:0] CH_INT    = 8'h49; // 'I'
    localparam logic [7:0] CH_LONG   = 8'h4A; // 'J'
    localparam logic [7:0] CH_CLASS  = 8'h4C; // 'L'
    localparam logic [7:0] CH_SHORT  = 8'h53; // 'S'
    localparam logic [7:0] CH_VOID   = 8'h56; // 'V'
    localparam logic [7:0] CH_BOOL   = 8'h5A; // 'Z'
    localparam logic [7:0] CH_ARRAY  = 8'h5B; // '['

    localparam int unsigned SLOT_W  = 16;
    localparam int unsigned FLAGS_W = 32;

    // Bit positions patched in the flags word
    localparam int unsigned FLAGS_KIND_LSB = 24;

    typedef enum logic [2:0] {
        PH_OPEN  = 3'd0,
        PH_ARGS  = 3'd1,
        PH_CLASS = 3'd2,
        PH_ARRAY = 3'd3,
        PH_RET   = 3'd4,
        PH_TAIL  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_START   = 3'd1,
        ERR_NOCLOSE = 3'd2,
        ERR_NORET   = 3'd3,
        ERR_BADRET  = 3'd4,
        ERR_UNTERM  = 3'd5,
        ERR_BADCH   = 3'd6,
        ERR_EXTRA   = 3'd7
    } err_t;

    typedef enum logic [3:0] {
        KIND_BYTE   = 4'd0,
        KIND_BOOL   = 4'd1,
        KIND_CHAR   = 4'd2,
        KIND_SHORT  = 4'd3,
        KIND_INT    = 4'd4,
        KIND_LONG   = 4'd5,
        KIND_FLOAT  = 4'd6,
        KIND_DOUBLE = 4'd7,
        KIND_REF    = 4'd8,
        KIND_VOID   = 4'd9
    } kind_t;

    // One descriptor character with its side fields
    typedef struct packed {
        logic [7:0]         ch;
        logic               no_receiver;
        logic [FLAGS_W-1:0] base_flags;
        logic               last;
    } item_t;

    // One result, field order as on the output tdata (error code lowest)
    typedef struct packed {
        logic [FLAGS_W-1:0] patched_flags;
        kind_t              return_kind;
        logic [SLOT_W-1:0]  slot_count;
        err_t               error_code;
    } result_t;

    // Return-kind code of a valid return character
    function automatic kind_t kind_of(input logic [7:0] c);
        kind_t k;
        begin
            case (c)
                CH_BYTE:   k = KIND_BYTE;
                CH_BOOL:   k = KIND_BOOL;
                CH_CHAR:   k = KIND_CHAR;
                CH_SHORT:  k = KIND_SHORT;
                CH_INT:    k = KIND_INT;
                CH_LONG:   k = KIND_LONG;
                CH_FLOAT:  k = KIND_FLOAT;
                CH_DOUBLE: k = KIND_DOUBLE;
                CH_CLASS:  k = KIND_REF;
                CH_ARRAY:  k = KIND_REF;
                CH_VOID:   k = KIND_VOID;
                default:   k = KIND_BYTE;
            endcase
            return k;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/method_descriptor_slot_counter.sv =====
// ----------------------------------------------------------------------------
// method_descriptor_slot_counter: JVM method descriptor slot counter
// Parses a method descriptor one character per transfer and, on the last
// character, returns error code, slot count, return kind and patched flags.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload (lowest bit first)                       Marks
//  s_axis   in   tdata: ch[7:0], base_flags[39:8]                 tuser: no_receiver
//                                                                 tlast: last char
//  m_axis   out  tdata: error_code[2:0], slot_count[18:3],        one transfer per
//                return_kind[22:19], patched_flags[54:23], pad    descriptor
//
//  One character per cycle sustained while m_axis takes results; the result
//  of the last character passes the input register, then the result
//  register, before it shows on m_axis.
//  Reset clears the parser to await a fresh descriptor; no start-up sweep.
//  A stalled result only holds back the last character of the next descriptor;
//  earlier characters keep flowing into the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module method_descriptor_slot_counter
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // ch[7:0], base_flags[39:8]
    input  wire logic        s_axis_tuser,  // no_receiver
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata   // error_code, slot_count, return_kind,
                                            // patched_flags, one zero pad bit
);

    mdsc_pkg::item_t   in_reg;
    logic              in_valid_reg, in_valid_next;
    mdsc_pkg::result_t result;
    mdsc_pkg::result_t out_reg;
    logic              out_valid_reg, out_valid_next;
    logic              advance;

    // Parser step: a last character needs room in the result register
    assign advance = in_valid_reg &&
                     (!in_reg.last || !out_valid_reg || m_axis_tready);

    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && in_reg.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_reg.ch          <= s_axis_tdata[7:0];
            in_reg.base_flags  <= s_axis_tdata[39:8];
            in_reg.no_receiver <= s_axis_tuser;
            in_reg.last        <= s_axis_tlast;
        end
    end

    mdsc_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_reg),
        .result (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_reg.last)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg};

endmodule

`default_nettype wire

// ===== sv/mdsc_parser.sv =====
// ----------------------------------------------------------------------------
// mdsc_parser: descriptor parser state and per-character update
// Holds the parse phase, running slot total, first error and return kind;
// consumes one character per step and forms the result on the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module mdsc_parser
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire mdsc_pkg::item_t  item,
    output mdsc_pkg::result_t     result
);

    mdsc_pkg::phase_t                  phase_reg, phase_next, phase_step;
    logic [mdsc_pkg::SLOT_W-1:0]       slot_reg, slot_next, slot_base, slot_step;
    mdsc_pkg::err_t                    err_reg, err_next, err_step;
    mdsc_pkg::kind_t                   kind_reg, kind_next, kind_step;
    logic                              at_start_reg, at_start_next;
    logic [1:0]                        slot_add;
    logic [mdsc_pkg::SLOT_W:0]         slot_sum;
    mdsc_pkg::err_t                    err_final;

    // Consume one character against the current state
    always_comb
    begin
        phase_step = phase_reg;
        slot_base  = slot_reg;
        err_step   = err_reg;
        kind_step  = kind_reg;
        slot_add   = 2'd0;
        if (at_start_reg)
        begin
            // receiver slot unless static
            slot_base = {{(mdsc_pkg::SLOT_W-1){1'b0}}, ~item.no_receiver};
            if (item.ch == mdsc_pkg::CH_OPEN)
            begin
                phase_step = mdsc_pkg::PH_ARGS;
            end
            else
            begin
                err_step = mdsc_pkg::ERR_START;
            end
        end
        else if (err_reg == mdsc_pkg::ERR_NONE)
        begin
            case (phase_reg)
                mdsc_pkg::PH_ARGS:
                begin
                    if (item.ch inside {mdsc_pkg::CH_BYTE, mdsc_pkg::CH_BOOL,
                                        mdsc_pkg::CH_SHORT, mdsc_pkg::CH_CHAR,
                                        mdsc_pkg::CH_INT, mdsc_pkg::CH_FLOAT})
                    begin
                        slot_add = 2'd1;
                    end
                    else if (item.ch inside {mdsc_pkg::CH_LONG, mdsc_pkg::CH_DOUBLE})
                    begin
                        slot_add = 2'd2;
                    end
                    else if (item.ch == mdsc_pkg::CH_CLASS)
                    begin
                        slot_add   = 2'd1;
                        phase_step = mdsc_pkg::PH_CLASS;
                    end
                    else if (item.ch == mdsc_pkg::CH_ARRAY)
                    begin
                        slot_add   = 2'd1;
                        phase_step = mdsc_pkg::PH_ARRAY;
                    end
                    else if (item.ch == mdsc_pkg::CH_CLOSE)
                    begin
                        phase_step = mdsc_pkg::PH_RET;
                    end
                    else
                    begin
                        err_step = mdsc_pkg::ERR_BADCH;
                    end
                end
                mdsc_pkg::PH_CLASS:
                begin
                    // ')' inside a class name is part of the name
                    if (item.ch == mdsc_pkg::CH_SEMI)
                    begin
                        phase_step = mdsc_pkg::PH_ARGS;
                    end
                end
                mdsc_pkg::PH_ARRAY:
                begin
                    // array prefix already counted; element closes it
                    if (item.ch == mdsc_pkg::CH_ARRAY)
                    begin
                        phase_step = mdsc_pkg::PH_ARRAY;
                    end
                    else if (item.ch == mdsc_pkg::CH_CLASS)
                    begin
                        phase_step = mdsc_pkg::PH_CLASS;
                    end
                    else if (item.ch == mdsc_pkg::CH_CLOSE)
                    begin
                        phase_step = mdsc_pkg::PH_RET;
                    end
                    else
                    begin
                        phase_step = mdsc_pkg::PH_ARGS;
                    end
                end
                mdsc_pkg::PH_RET:
                begin
                    if (item.ch inside {mdsc_pkg::CH_BYTE, mdsc_pkg::CH_BOOL,
                                        mdsc_pkg::CH_CHAR, mdsc_pkg::CH_SHORT,
                                        mdsc_pkg::CH_INT, mdsc_pkg::CH_LONG,
                                        mdsc_pkg::CH_FLOAT, mdsc_pkg::CH_DOUBLE,
                                        mdsc_pkg::CH_CLASS, mdsc_pkg::CH_ARRAY,
                                        mdsc_pkg::CH_VOID})
                    begin
                        kind_step  = mdsc_pkg::kind_of(item.ch);
                        phase_step = mdsc_pkg::PH_TAIL;
                    end
                    else
                    begin
                        err_step = mdsc_pkg::ERR_BADRET;
                    end
                end
                mdsc_pkg::PH_TAIL:
                begin
                    // trailing bytes ignored, but a second close is not
                    if (item.ch == mdsc_pkg::CH_CLOSE)
                    begin
                        err_step = mdsc_pkg::ERR_EXTRA;
                    end
                end
                default:
                begin
                    err_step = mdsc_pkg::ERR_START;
                end
            endcase
        end
    end

    // Saturating slot accumulate
    assign slot_sum  = {1'b0, slot_base} + {{(mdsc_pkg::SLOT_W-1){1'b0}}, slot_add};
    assign slot_step = slot_sum[mdsc_pkg::SLOT_W] ? {mdsc_pkg::SLOT_W{1'b1}}
                                                  : slot_sum[mdsc_pkg::SLOT_W-1:0];

    // Next state: back to the reset state after the last character
    always_comb
    begin
        phase_next    = phase_reg;
        slot_next     = slot_reg;
        err_next      = err_reg;
        kind_next     = kind_reg;
        at_start_next = at_start_reg;
        if (step)
        begin
            if (item.last)
            begin
                phase_next    = mdsc_pkg::PH_OPEN;
                slot_next     = '0;
                err_next      = mdsc_pkg::ERR_NONE;
                kind_next     = mdsc_pkg::KIND_BYTE;
                at_start_next = 1'b1;
            end
            else
            begin
                phase_next    = phase_step;
                slot_next     = slot_step;
                err_next      = err_step;
                kind_next     = kind_step;
                at_start_next = 1'b0;
            end
        end
    end

    // Result of the descriptor ending on this character
    always_comb
    begin
        err_final = err_step;
        if (err_step == mdsc_pkg::ERR_NONE)
        begin
            case (phase_step)
                mdsc_pkg::PH_ARGS:  err_final = mdsc_pkg::ERR_NOCLOSE;
                mdsc_pkg::PH_CLASS: err_final = mdsc_pkg::ERR_NOCLOSE;
                mdsc_pkg::PH_ARRAY: err_final = mdsc_pkg::ERR_NOCLOSE;
                mdsc_pkg::PH_RET:   err_final = mdsc_pkg::ERR_NORET;
                mdsc_pkg::PH_TAIL:  err_final = mdsc_pkg::ERR_NONE;
                default:            err_final = mdsc_pkg::ERR_START;
            endcase
        end
        result.error_code = err_final;
        if (err_final == mdsc_pkg::ERR_NONE)
        begin
            result.slot_count    = slot_step;
            result.return_kind   = kind_step;
            result.patched_flags = {
                item.base_flags[mdsc_pkg::FLAGS_W-1:mdsc_pkg::FLAGS_KIND_LSB+4],
                kind_step,
                item.base_flags[mdsc_pkg::FLAGS_KIND_LSB-1:8],
                slot_step[7:0]
            };
        end
        else
        begin
            result.slot_count    = '0;
            result.return_kind   = mdsc_pkg::KIND_BYTE;
            result.patched_flags = '0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mdsc_pkg::PH_OPEN;
            slot_reg     <= '0;
            err_reg      <= mdsc_pkg::ERR_NONE;
            kind_reg     <= mdsc_pkg::KIND_BYTE;
            at_start_reg <= 1'b1;
        end
        else
        begin
            phase_reg    <= phase_next;
            slot_reg     <= slot_next;
            err_reg      <= err_next;
            kind_reg     <= kind_next;
            at_start_reg <= at_start_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mdsc_checker.sv =====
// ----------------------------------------------------------------------------
// mdsc_checker: port-level checks for the descriptor slot counter
// Watches the result channel for handshake holding and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module mdsc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);

    // Stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Stalled result holds its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Error results carry nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != mdsc_pkg::ERR_NONE)
        |-> (m_axis_tdata[55:3] == '0))
        else $error("error result has non-zero payload");

    // Good results: flags carry count and kind, kind in range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == mdsc_pkg::ERR_NONE)
        |-> (m_axis_tdata[30:23] == m_axis_tdata[10:3]) &&
            (m_axis_tdata[50:47] == m_axis_tdata[22:19]) &&
            (m_axis_tdata[22:19] <= mdsc_pkg::KIND_VOID) &&
            !m_axis_tdata[55])
        else $error("good result inconsistent");

endmodule

bind method_descriptor_slot_counter mdsc_checker u_mdsc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb_method_descriptor_slot_counter.sv =====
// ----------------------------------------------------------------------------
// tb_method_descriptor_slot_counter: self-checking bench for the slot counter
// Streams JVM method descriptors one character per transfer, predicts the
// result of each descriptor in step with the accepted characters and checks
// every result transfer field by field. Directed corner cases come first,
// then one long descriptor of wide arguments whose count wraps the low flag
// byte, then random well-formed, truncated, corrupted and noise descriptors
// with random gaps and output stalls.
// ----------------------------------------------------------------------------

module tb_method_descriptor_slot_counter;

    localparam int MAX_GAP   = 20;
    localparam int MAX_STALL = 30;
    localparam int RAND_CHARS = 850;
    localparam int RAND_DESCS = 40;

    // Donor flags choice per descriptor
    localparam int DONOR_RANDOM = 0;
    localparam int DONOR_ZEROS  = 1;
    localparam int DONOR_ONES   = 2;

    // One queued character; drain holds it back until all results are in
    typedef struct {
        mdsc_pkg::item_t it;
        bit              drain;
    } char_xfer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // ch[7:0], base_flags[39:8]
    logic        s_axis_tuser = 1'b0;  // no_receiver
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // error_code, slot_count, return_kind,
                                       // patched_flags, pad

    char_xfer_t          char_queue[$];
    mdsc_pkg::result_t   due_results[$];
    logic [7:0]          desc_chars[$];

    // Descriptor tracker state
    mdsc_pkg::phase_t    trk_phase;
    logic [15:0]         trk_slots;
    mdsc_pkg::err_t      trk_err;
    mdsc_pkg::kind_t     trk_ret;
    bit                  trk_fresh;

    longint      cycles = 0;
    longint      cycle_limit = 64'd100000000;
    int          n_chars = 0;
    int          n_descs = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          in_taken = 1'b0;
    bit          failed = 1'b0;
    wire         calm = (cycles % 1000) < 200;

    method_descriptor_slot_counter u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Character tables
    // ------------------------------------------------------------------------

    // B Z C S I F J D
    function automatic logic [7:0] prim_char(input int i);
        logic [7:0] c;
        case (i)
            0:       c = mdsc_pkg::CH_BYTE;
            1:       c = mdsc_pkg::CH_BOOL;
            2:       c = mdsc_pkg::CH_CHAR;
            3:       c = mdsc_pkg::CH_SHORT;
            4:       c = mdsc_pkg::CH_INT;
            5:       c = mdsc_pkg::CH_FLOAT;
            6:       c = mdsc_pkg::CH_LONG;
            default: c = mdsc_pkg::CH_DOUBLE;
        endcase
        return c;
    endfunction

    // Any valid return character
    function automatic logic [7:0] ret_char(input int i);
        logic [7:0] c;
        case (i)
            8:       c = mdsc_pkg::CH_CLASS;
            9:       c = mdsc_pkg::CH_ARRAY;
            10:      c = mdsc_pkg::CH_VOID;
            default: c = prim_char(i);
        endcase
        return c;
    endfunction

    // Return kind of a character; 0 when it cannot be a return type
    function automatic bit return_kind_of(input logic [7:0] c,
                                          output mdsc_pkg::kind_t k);
        bit ok;
        ok = 1'b1;
        k = mdsc_pkg::KIND_VOID;
        case (c)
            mdsc_pkg::CH_BYTE:   k = mdsc_pkg::KIND_BYTE;
            mdsc_pkg::CH_BOOL:   k = mdsc_pkg::KIND_BOOL;
            mdsc_pkg::CH_CHAR:   k = mdsc_pkg::KIND_CHAR;
            mdsc_pkg::CH_SHORT:  k = mdsc_pkg::KIND_SHORT;
            mdsc_pkg::CH_INT:    k = mdsc_pkg::KIND_INT;
            mdsc_pkg::CH_LONG:   k = mdsc_pkg::KIND_LONG;
            mdsc_pkg::CH_FLOAT:  k = mdsc_pkg::KIND_FLOAT;
            mdsc_pkg::CH_DOUBLE: k = mdsc_pkg::KIND_DOUBLE;
            mdsc_pkg::CH_CLASS:  k = mdsc_pkg::KIND_REF;
            mdsc_pkg::CH_ARRAY:  k = mdsc_pkg::KIND_REF;
            mdsc_pkg::CH_VOID:   k = mdsc_pkg::KIND_VOID;
            default:             ok = 1'b0;
        endcase
        return ok;
    endfunction

    // ------------------------------------------------------------------------
    // Descriptor tracker: follows the accepted characters, queues the result
    // ------------------------------------------------------------------------

    task automatic clear_tracker();
        trk_phase = mdsc_pkg::PH_OPEN;
        trk_slots = '0;
        trk_err   = mdsc_pkg::ERR_NONE;
        trk_ret   = mdsc_pkg::KIND_BYTE;
        trk_fresh = 1'b1;
    endtask

    task automatic add_slots(input int n);
        logic [16:0] sum;
        sum = {1'b0, trk_slots} + 17'(n);
        trk_slots = sum[16] ? 16'hFFFF : sum[15:0];
    endtask

    task automatic track_char(input mdsc_pkg::item_t it);
        mdsc_pkg::kind_t   k;
        mdsc_pkg::err_t    e;
        mdsc_pkg::result_t res;
        if (trk_fresh)
        begin
            trk_fresh = 1'b0;
            trk_slots = it.no_receiver ? 16'd0 : 16'd1;
            if (it.ch == mdsc_pkg::CH_OPEN)
                trk_phase = mdsc_pkg::PH_ARGS;
            else
                trk_err = mdsc_pkg::ERR_START;
        end
        else if (trk_err == mdsc_pkg::ERR_NONE)
        begin
            case (trk_phase)
                mdsc_pkg::PH_ARGS:
                    case (it.ch)
                        mdsc_pkg::CH_BYTE, mdsc_pkg::CH_BOOL, mdsc_pkg::CH_SHORT,
                        mdsc_pkg::CH_CHAR, mdsc_pkg::CH_INT, mdsc_pkg::CH_FLOAT:
                            add_slots(1);
                        mdsc_pkg::CH_LONG, mdsc_pkg::CH_DOUBLE:
                            add_slots(2);
                        mdsc_pkg::CH_CLASS:
                        begin
                            add_slots(1);
                            trk_phase = mdsc_pkg::PH_CLASS;
                        end
                        mdsc_pkg::CH_ARRAY:
                        begin
                            add_slots(1);
                            trk_phase = mdsc_pkg::PH_ARRAY;
                        end
                        mdsc_pkg::CH_CLOSE:
                            trk_phase = mdsc_pkg::PH_RET;
                        default:
                            trk_err = mdsc_pkg::ERR_BADCH;
                    endcase
                mdsc_pkg::PH_CLASS:
                    if (it.ch == mdsc_pkg::CH_SEMI)
                        trk_phase = mdsc_pkg::PH_ARGS;
                mdsc_pkg::PH_ARRAY:
                    case (it.ch)
                        mdsc_pkg::CH_ARRAY: ;
                        mdsc_pkg::CH_CLASS: trk_phase = mdsc_pkg::PH_CLASS;
                        mdsc_pkg::CH_CLOSE: trk_phase = mdsc_pkg::PH_RET;
                        default:            trk_phase = mdsc_pkg::PH_ARGS;
                    endcase
                mdsc_pkg::PH_RET:
                    if (return_kind_of(it.ch, k))
                    begin
                        trk_ret = k;
                        trk_phase = mdsc_pkg::PH_TAIL;
                    end
                    else
                        trk_err = mdsc_pkg::ERR_BADRET;
                mdsc_pkg::PH_TAIL:
                    if (it.ch == mdsc_pkg::CH_CLOSE)
                        trk_err = mdsc_pkg::ERR_EXTRA;
                default:
                    trk_err = mdsc_pkg::ERR_START;
            endcase
        end

        if (it.last)
        begin
            e = trk_err;
            if (e == mdsc_pkg::ERR_NONE)
            begin
                if (trk_phase inside {mdsc_pkg::PH_ARGS, mdsc_pkg::PH_CLASS,
                                      mdsc_pkg::PH_ARRAY})
                    e = mdsc_pkg::ERR_NOCLOSE;
                else if (trk_phase == mdsc_pkg::PH_RET)
                    e = mdsc_pkg::ERR_NORET;
                else if (trk_phase != mdsc_pkg::PH_TAIL)
                    e = mdsc_pkg::ERR_START;
            end
            res.error_code = e;
            if (e == mdsc_pkg::ERR_NONE)
            begin
                res.slot_count    = trk_slots;
                res.return_kind   = trk_ret;
                res.patched_flags = {it.base_flags[31:28], trk_ret,
                                     it.base_flags[23:8], trk_slots[7:0]};
            end
            else
            begin
                res.slot_count    = '0;
                res.return_kind   = mdsc_pkg::KIND_BYTE;
                res.patched_flags = '0;
            end
            due_results.push_back(res);
            clear_tracker();
        end
    endtask

    // ------------------------------------------------------------------------
    // Descriptor building
    // ------------------------------------------------------------------------

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            desc_chars.push_back(s[i]);
    endtask

    // Class name body and ';' - a ')' inside the name is not a split
    task automatic add_name();
        logic [7:0] c;
        repeat ($urandom_range(0, 4))
        begin
            c = 8'($urandom_range(8'h21, 8'h7E));
            if ($urandom_range(0, 9) == 0)
                c = mdsc_pkg::CH_CLOSE;
            else if (c == mdsc_pkg::CH_SEMI)
                c = 8'h61;
            desc_chars.push_back(c);
        end
        desc_chars.push_back(mdsc_pkg::CH_SEMI);
    endtask

    task automatic add_arg();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            desc_chars.push_back(prim_char($urandom_range(0, 5)));
        else if (r < 6)
            desc_chars.push_back($urandom_range(0, 1) ? mdsc_pkg::CH_LONG
                                                      : mdsc_pkg::CH_DOUBLE);
        else if (r < 8)
        begin
            desc_chars.push_back(mdsc_pkg::CH_CLASS);
            add_name();
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                desc_chars.push_back(mdsc_pkg::CH_ARRAY);
            r = $urandom_range(0, 9);
            if (r < 7)
                desc_chars.push_back(prim_char($urandom_range(0, 7)));
            else if (r < 9)
            begin
                desc_chars.push_back(mdsc_pkg::CH_CLASS);
                add_name();
            end
            else
                desc_chars.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly well-formed; some truncated, corrupted or pure noise
    task automatic make_random_desc();
        int r;
        int n;
        int cut;
        logic [7:0] rc;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            repeat ($urandom_range(1, 8))
                desc_chars.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                desc_chars[0] = mdsc_pkg::CH_OPEN;
        end
        else
        begin
            desc_chars.push_back(mdsc_pkg::CH_OPEN);
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(30, 60)
                                             : $urandom_range(0, 6);
            repeat (n)
                add_arg();
            desc_chars.push_back(mdsc_pkg::CH_CLOSE);
            rc = ret_char($urandom_range(0, 10));
            desc_chars.push_back(rc);
            if (rc == mdsc_pkg::CH_CLASS)
                add_name();
            else if (rc == mdsc_pkg::CH_ARRAY)
                desc_chars.push_back(prim_char($urandom_range(0, 7)));
            // trailing bytes after the return type
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    desc_chars.push_back($urandom_range(0, 1) ? mdsc_pkg::CH_CLOSE
                                                              : 8'($urandom));
            if (r < 22)
            begin
                cut = $urandom_range(1, desc_chars.size());
                while (desc_chars.size() > cut)
                    void'(desc_chars.pop_back());
            end
            else if (r < 30)
                desc_chars[$urandom_range(0, desc_chars.size() - 1)] = 8'($urandom);
        end
    endtask

    // Move the built descriptor onto the character queue
    task automatic commit_desc(input int donor_mode, input bit drain);
        char_xfer_t x;
        int i;
        for (i = 0; i < desc_chars.size(); i++)
        begin
            x.it.ch          = desc_chars[i];
            x.it.no_receiver = 1'($urandom_range(0, 1));
            case (donor_mode)
                DONOR_ZEROS: x.it.base_flags = '0;
                DONOR_ONES:  x.it.base_flags = '1;
                default:     x.it.base_flags = $urandom;
            endcase
            x.it.last = (i == desc_chars.size() - 1);
            x.drain   = drain && (i == 0);
            char_queue.push_back(x);
        end
        n_chars += desc_chars.size();
        n_descs++;
        desc_chars.delete();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------

    initial
    begin
        int rand_chars;
        int rand_descs;
        int i;

        clear_tracker();

        // bad start on a zero byte
        desc_chars.push_back(8'h00);
        commit_desc(DONOR_ZEROS, 1'b0);
        // open parenthesis only: no close
        add_text("(");
        commit_desc(DONOR_RANDOM, 1'b0);
        // end right after the close: no return
        add_text("()");
        commit_desc(DONOR_RANDOM, 1'b0);
        add_text("()Q");
        commit_desc(DONOR_RANDOM, 1'b0);
        // close after the return type
        add_text("(Z)V)");
        commit_desc(DONOR_ONES, 1'b0);
        // ')' inside a class name, then an array cut short by the close
        add_text("(L);[)J");
        commit_desc(DONOR_ONES, 1'b0);
        // bad argument character 0xFF
        desc_chars.push_back(mdsc_pkg::CH_OPEN);
        desc_chars.push_back(8'hFF);
        add_text(")I");
        commit_desc(DONOR_RANDOM, 1'b0);
        // unterminated class name
        add_text("(Lx");
        commit_desc(DONOR_RANDOM, 1'b0);

        // long run of wide arguments, after everything before it has drained
        desc_chars.push_back(mdsc_pkg::CH_OPEN);
        for (i = 0; i < 200; i++)
            desc_chars.push_back(i[0] ? mdsc_pkg::CH_DOUBLE : mdsc_pkg::CH_LONG);
        add_text(")V");
        commit_desc(DONOR_RANDOM, 1'b1);

        rand_chars = 0;
        rand_descs = 0;
        while (rand_chars < RAND_CHARS || rand_descs < RAND_DESCS)
        begin
            make_random_desc();
            rand_chars += desc_chars.size();
            commit_desc(DONOR_RANDOM, (rand_descs % 20) == 0);
            rand_descs++;
        end

        cycle_limit = 4 * (longint'(n_chars) * (1 + MAX_GAP)
                           + longint'(n_descs) * (MAX_STALL + 4)) + 10000;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (char_queue.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (failed)
            $display("tb_method_descriptor_slot_counter NOT OK");
        else
            $display("tb_method_descriptor_slot_counter OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input driver: one transfer per queued character, random gaps
    // ------------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, MAX_GAP);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (char_queue.size() != 0
                     && !(char_queue[0].drain && due_results.size() != 0))
            begin
                s_axis_tdata  <= {char_queue[0].it.base_flags, char_queue[0].it.ch};
                s_axis_tuser  <= char_queue[0].it.no_receiver;
                s_axis_tlast  <= char_queue[0].it.last;
                s_axis_tvalid <= 1'b1;
                gap_left      <= pick_gap();
                void'(char_queue.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result side back-pressure: short stalls mostly, a few long ones
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm)
            begin
                case ($urandom_range(0, 99)) inside
                    [0:14]:  stall_left <= $urandom_range(1, 3);
                    [15:17]: stall_left <= $urandom_range(8, MAX_STALL);
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: track accepted characters, check result transfers
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        mdsc_pkg::result_t act;
        mdsc_pkg::result_t exp_res;
        mdsc_pkg::item_t   it;

        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            act = mdsc_pkg::result_t'(m_axis_tdata[54:0]);
            if (due_results.size() == 0)
            begin
                $error("unexpected result transfer: %h", m_axis_tdata);
                failed = 1'b1;
            end
            else
            begin
                exp_res = due_results.pop_front();
                if (act.error_code !== exp_res.error_code)
                begin
                    $error("error_code: expected %0d, got %0d",
                           exp_res.error_code, act.error_code);
                    failed = 1'b1;
                end
                if (act.slot_count !== exp_res.slot_count)
                begin
                    $error("slot_count: expected %0d, got %0d",
                           exp_res.slot_count, act.slot_count);
                    failed = 1'b1;
                end
                if (act.return_kind !== exp_res.return_kind)
                begin
                    $error("return_kind: expected %0d, got %0d",
                           exp_res.return_kind, act.return_kind);
                    failed = 1'b1;
                end
                if (act.patched_flags !== exp_res.patched_flags)
                begin
                    $error("patched_flags: expected %h, got %h",
                           exp_res.patched_flags, act.patched_flags);
                    failed = 1'b1;
                end
            end
        end

        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            it.ch          = s_axis_tdata[7:0];
            it.base_flags  = s_axis_tdata[39:8];
            it.no_receiver = s_axis_tuser;
            it.last        = s_axis_tlast;
            track_char(it);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= cycle_limit)
        begin
            $display("tb_method_descriptor_slot_counter NOT OK");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
sv/mdsc_pkg.sv
sv/mdsc_parser.sv
sv/method_descriptor_slot_counter.sv
sv/mdsc_checker.sv
tb/tb_method_descriptor_slot_counter.sv
